FILE: sv/gtle_pkg.sv
// Shared types, constants and the control-code expansion table for the text layout expander.
package gtle_pkg;

	localparam int unsigned GLYPH_SIZE = 8;
	localparam logic [15:0] GLYPH_STEP = 16'(GLYPH_SIZE);

	localparam logic [7:0] CODE_NUL     = 8'h00;
	localparam logic [7:0] CODE_END     = 8'h50;
	localparam logic [7:0] CODE_NEWLINE = 8'h4F;
	localparam logic [7:0] CTRL_LO      = 8'h48;
	localparam logic [7:0] CTRL_HI      = 8'h5F;

	localparam logic KIND_GLYPH = 1'b0;
	localparam logic KIND_END   = 1'b1;

	typedef struct packed {
		logic [7:0]         char_code;
		logic               first;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
	} req_word_t;

	typedef struct packed {
		logic               kind;
		logic signed [15:0] dest_x;
		logic signed [15:0] dest_y;
		logic [3:0]         tile_col;
		logic [3:0]         tile_row;
		logic signed [15:0] drawn_width;
		logic               last;
	} rsp_word_t;

	// How the datapath classes the word at its input
	typedef enum logic [2:0] {
		CLS_IGNORE,
		CLS_END,
		CLS_NEWLINE,
		CLS_EXPAND,
		CLS_NONE,
		CLS_GLYPH
	} cls_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXPAND
	} ctl_state_t;

	typedef struct packed {
		logic take;
		logic emit_exp;
	} dp_cmd_t;

	typedef struct packed {
		cls_t cls;
		logic exp_last;
		logic out_free;
	} dp_sts_t;

	// Number of glyphs a control code expands to, indexed by code minus CTRL_LO
	function automatic logic [2:0] exp_count(input logic [4:0] sel);
		logic [2:0] n;
		case (sel)
			5'h02:   n = 3'd2;
			5'h0C:   n = 3'd4;
			5'h0E:   n = 3'd1;
			5'h13:   n = 3'd2;
			5'h14:   n = 3'd2;
			5'h15:   n = 3'd7;
			5'h16:   n = 3'd6;
			default: n = 3'd0;
		endcase
		return n;
	endfunction

	// Glyph codes of an expansion, element 0 drawn first
	function automatic logic [6:0][7:0] exp_glyphs(input logic [4:0] sel);
		logic [6:0][7:0] g;
		g = '0;
		case (sel)
			5'h02: begin
				g[0] = 8'hE1; g[1] = 8'hE2;
			end
			5'h0C: begin
				g[0] = 8'h8F; g[1] = 8'h8E; g[2] = 8'h8A; g[3] = 8'hBA;
			end
			5'h0E: begin
				g[0] = 8'h75;
			end
			5'h13: begin
				g[0] = 8'h8F; g[1] = 8'h82;
			end
			5'h14: begin
				g[0] = 8'h82; g[1] = 8'h8C;
			end
			5'h15: begin
				g[0] = 8'h93; g[1] = 8'h91; g[2] = 8'h80; g[3] = 8'h88;
				g[4] = 8'h8D; g[5] = 8'h84; g[6] = 8'h91;
			end
			5'h16: begin
				g[0] = 8'h91; g[1] = 8'h8E; g[2] = 8'h82; g[3] = 8'h8A;
				g[4] = 8'h84; g[5] = 8'h93;
			end
			default: begin
				g = '0;
			end
		endcase
		return g;
	endfunction

endpackage

FILE: sv/gtle_ctrl.sv
// Controller state machine: gates input words and steps through control-code expansions.
module gtle_ctrl import gtle_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	ctl_state_t state_q, state_d;

	// Hold state, move to expansion on a macro code, leave after its last glyph
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && sts.out_free && sts.cls == CLS_EXPAND)
					state_d = ST_EXPAND;
			end
			ST_EXPAND: begin
				if (sts.out_free && sts.exp_last)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Issue take and emit commands
	always_comb begin
		req_ready    = 1'b0;
		cmd.take     = 1'b0;
		cmd.emit_exp = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = sts.out_free;
				cmd.take  = req_valid && sts.out_free;
			end
			ST_EXPAND: begin
				cmd.emit_exp = sts.out_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

FILE: sv/gtle_dp.sv
// Datapath: cursor and origin registers, code classing, expansion counter and output register.
module gtle_dp import gtle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  req_word_t req,
	input  dp_cmd_t   cmd,
	output dp_sts_t   sts,
	input  logic      rsp_ready,
	output logic      rsp_valid,
	output rsp_word_t rsp
);

	logic [15:0] cur_x_q, cur_y_q, org_x_q;
	logic        ended_q;
	logic [4:0]  exp_sel_q;
	logic [2:0]  exp_cnt_q, exp_idx_q;
	logic        out_valid_q;
	rsp_word_t   out_q;

	logic [15:0]     cx_eff, cy_eff, ox_eff;
	logic            ended_eff;
	logic [7:0]      ctrl_off;
	logic [4:0]      sel;
	logic [2:0]      sel_cnt;
	cls_t            cls;
	logic [6:0][7:0] exp_tab;
	logic [7:0]      exp_code;
	logic            load_out;

	// Apply the start fields when a new string begins
	assign cx_eff    = req.first ? req.start_x : cur_x_q;
	assign cy_eff    = req.first ? req.start_y : cur_y_q;
	assign ox_eff    = req.first ? req.start_x : org_x_q;
	assign ended_eff = req.first ? 1'b0 : ended_q;

	assign ctrl_off = req.char_code - CTRL_LO;
	assign sel      = ctrl_off[4:0];
	assign sel_cnt  = exp_count(sel);

	// Class the incoming word
	always_comb begin
		if (ended_eff)
			cls = CLS_IGNORE;
		else if (req.char_code == CODE_NUL || req.char_code == CODE_END)
			cls = CLS_END;
		else if (req.char_code == CODE_NEWLINE)
			cls = CLS_NEWLINE;
		else if (req.char_code inside {[CTRL_LO:CTRL_HI]})
			cls = (sel_cnt != 3'd0) ? CLS_EXPAND : CLS_NONE;
		else
			cls = CLS_GLYPH;
	end

	assign exp_tab  = exp_glyphs(exp_sel_q);
	assign exp_code = exp_tab[exp_idx_q];

	assign sts.cls      = cls;
	assign sts.exp_last = (exp_idx_q == exp_cnt_q - 3'd1);
	assign sts.out_free = !out_valid_q || rsp_ready;

	assign load_out = (cmd.take && (cls == CLS_END || cls == CLS_GLYPH)) || cmd.emit_exp;

	// Advance cursor, latch expansions, track end of string
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q   <= '0;
			cur_y_q   <= '0;
			org_x_q   <= '0;
			ended_q   <= 1'b1;
			exp_sel_q <= '0;
			exp_cnt_q <= '0;
			exp_idx_q <= '0;
		end else if (cmd.take) begin
			cur_x_q <= cx_eff;
			cur_y_q <= cy_eff;
			org_x_q <= ox_eff;
			ended_q <= ended_eff;
			case (cls)
				CLS_END: begin
					ended_q <= 1'b1;
				end
				CLS_NEWLINE: begin
					cur_x_q <= ox_eff;
					cur_y_q <= cy_eff + GLYPH_STEP;
				end
				CLS_GLYPH: begin
					cur_x_q <= cx_eff + GLYPH_STEP;
				end
				CLS_EXPAND: begin
					exp_sel_q <= sel;
					exp_cnt_q <= sel_cnt;
					exp_idx_q <= '0;
				end
				default: begin
					ended_q <= ended_eff;
				end
			endcase
		end else if (cmd.emit_exp) begin
			cur_x_q   <= cur_x_q + GLYPH_STEP;
			exp_idx_q <= exp_idx_q + 3'd1;
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (rsp_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_exp) begin
			out_q.kind        <= KIND_GLYPH;
			out_q.dest_x      <= cur_x_q;
			out_q.dest_y      <= cur_y_q;
			out_q.tile_col    <= exp_code[3:0];
			out_q.tile_row    <= exp_code[7:4];
			out_q.drawn_width <= '0;
			out_q.last        <= sts.exp_last;
		end else if (cmd.take && cls == CLS_END) begin
			out_q.kind        <= KIND_END;
			out_q.dest_x      <= '0;
			out_q.dest_y      <= '0;
			out_q.tile_col    <= '0;
			out_q.tile_row    <= '0;
			out_q.drawn_width <= cx_eff - ox_eff;
			out_q.last        <= 1'b1;
		end else if (cmd.take && cls == CLS_GLYPH) begin
			out_q.kind        <= KIND_GLYPH;
			out_q.dest_x      <= cx_eff;
			out_q.dest_y      <= cy_eff;
			out_q.tile_col    <= req.char_code[3:0];
			out_q.tile_row    <= req.char_code[7:4];
			out_q.drawn_width <= '0;
			out_q.last        <= 1'b1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

endmodule

FILE: sv/glyph_text_layout_expander_unit.sv
// Top level of the text layout expander: controller plus datapath.
// Timing: a plain glyph or end word appears in the cycle after its character is taken; the
// first glyph of a macro code passes the expansion state, then the single output register.
// Throughput: one plain character per cycle while the output is free; a macro code holds off
// new characters until the expansion counter has fed all its glyphs, one a cycle when free.
// Reset (arst_n low, asynchronous): cursor and origin clear, output empty, and the block
// ignores characters until one arrives with first set.
module glyph_text_layout_expander_unit import gtle_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	gtle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	gtle_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_ready (rsp_ready),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

FILE: sv/gtle_chk.sv
// Port-level checker for the text layout expander, bound to the top level.
module gtle_chk import gtle_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      req_valid,
	input logic      req_ready,
	input req_word_t req,
	input logic      rsp_valid,
	input logic      rsp_ready,
	input rsp_word_t rsp
);

	// A stalled output word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("output word changed while stalled");

	// An end word is always last and carries no glyph position
	a_end_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_END |->
			rsp.last && rsp.dest_x == 16'sd0 && rsp.dest_y == 16'sd0)
		else $error("malformed end word");

	// A glyph word reports no width
	a_glyph_width: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_GLYPH |-> rsp.drawn_width == 16'sd0)
		else $error("glyph word with non-zero width");

	// Mid-expansion, no new character is taken
	a_exp_block: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.kind == KIND_GLYPH && !rsp.last |-> !req_ready)
		else $error("input taken during an expansion");

endmodule

bind glyph_text_layout_expander_unit gtle_chk u_gtle_chk (.*);

FILE: verif/tb.sv
// Self-checking testbench for the glyph text layout expander: random strings, handshake stalls.
`timescale 1ns / 1ps

module tb;
	import gtle_pkg::*;

	// Control codes with their own behaviour
	localparam logic [7:0] CODE_PKMN     = 8'h4A;
	localparam logic [7:0] CODE_PLAYER   = 8'h52;
	localparam logic [7:0] CODE_RIVAL    = 8'h53;
	localparam logic [7:0] CODE_POKE     = 8'h54;
	localparam logic [7:0] CODE_ELLIPSIS = 8'h56;
	localparam logic [7:0] CODE_PC       = 8'h5B;
	localparam logic [7:0] CODE_TM       = 8'h5C;
	localparam logic [7:0] CODE_TRAINER  = 8'h5D;
	localparam logic [7:0] CODE_ROCKET   = 8'h5E;

	localparam int RANDOM_ITEMS = 300;
	localparam int HOLD_CYCLES  = 200;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_ready;
	req_word_t req = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	glyph_text_layout_expander_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always #10 clk = ~clk;

	req_word_t pending_chars[$];
	rsp_word_t expected_glyphs[$];
	rsp_word_t want;
	int        chars_offered = 0;
	int        chars_taken = 0;
	int        mismatches = 0;

	// Layout state kept alongside the block
	logic [15:0] pen_x = '0;
	logic [15:0] pen_y = '0;
	logic [15:0] margin_x = '0;
	logic        text_done = 1'b1;

	function automatic req_word_t make_word(input logic [7:0] c, input logic f,
			input logic [15:0] sx, input logic [15:0] sy);
		req_word_t w;
		w.char_code = c;
		w.first     = f;
		w.start_x   = sx;
		w.start_y   = sy;
		return w;
	endfunction

	// Pick a code from the control range, never the end code
	function automatic logic [7:0] pick_control();
		logic [7:0] c;
		c = 8'($urandom_range(CTRL_LO, CTRL_HI));
		if (c == CODE_END)
			c = CODE_NEWLINE;
		return c;
	endfunction

	// Pick a code that draws itself as one glyph
	function automatic logic [7:0] pick_plain();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (c >= CTRL_LO && c <= CTRL_HI);
		return c;
	endfunction

	// Advance the layout state by one word and queue the glyphs it draws
	task automatic predict_layout(input req_word_t w);
		logic [0:6][7:0] seq;
		rsp_word_t       r;
		int              n;
		int              i;
		seq = '0;
		n = 0;
		if (w.first) begin
			pen_x     = w.start_x;
			pen_y     = w.start_y;
			margin_x  = w.start_x;
			text_done = 1'b0;
		end
		if (!text_done) begin
			if (w.char_code == CODE_NUL || w.char_code == CODE_END) begin
				r             = '0;
				r.kind        = KIND_END;
				r.drawn_width = pen_x - margin_x;
				r.last        = 1'b1;
				expected_glyphs.push_back(r);
				text_done = 1'b1;
			end else if (w.char_code == CODE_NEWLINE) begin
				pen_x = margin_x;
				pen_y = pen_y + GLYPH_STEP;
			end else if (w.char_code >= CTRL_LO && w.char_code <= CTRL_HI) begin
				case (w.char_code)
					CODE_PKMN: begin
						n = 2; seq[0] = 8'hE1; seq[1] = 8'hE2;
					end
					CODE_POKE: begin
						n = 4; seq[0] = 8'h8F; seq[1] = 8'h8E; seq[2] = 8'h8A; seq[3] = 8'hBA;
					end
					CODE_ELLIPSIS: begin
						n = 1; seq[0] = 8'h75;
					end
					CODE_PC: begin
						n = 2; seq[0] = 8'h8F; seq[1] = 8'h82;
					end
					CODE_TM: begin
						n = 2; seq[0] = 8'h82; seq[1] = 8'h8C;
					end
					CODE_TRAINER: begin
						n = 7;
						seq[0] = 8'h93; seq[1] = 8'h91; seq[2] = 8'h80; seq[3] = 8'h88;
						seq[4] = 8'h8D; seq[5] = 8'h84; seq[6] = 8'h91;
					end
					CODE_ROCKET: begin
						n = 6;
						seq[0] = 8'h91; seq[1] = 8'h8E; seq[2] = 8'h82; seq[3] = 8'h8A;
						seq[4] = 8'h84; seq[5] = 8'h93;
					end
					default: begin
						n = 0;
					end
				endcase
			end else begin
				n = 1;
				seq[0] = w.char_code;
			end
			for (i = 0; i < n; i++) begin
				r          = '0;
				r.kind     = KIND_GLYPH;
				r.dest_x   = pen_x;
				r.dest_y   = pen_y;
				r.tile_col = seq[i][3:0];
				r.tile_row = seq[i][7:4];
				r.last     = (i == n - 1);
				expected_glyphs.push_back(r);
				pen_x = pen_x + GLYPH_STEP;
			end
		end
	endtask

	// Check results against the oldest expectation, then predict from the taken word
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (expected_glyphs.size() == 0) begin
					$error("result word with nothing expected");
					mismatches++;
				end else begin
					want = expected_glyphs.pop_front();
					if (rsp.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, rsp.kind);
						mismatches++;
					end
					if (rsp.dest_x !== want.dest_x) begin
						$error("dest_x: expected %0d, got %0d", want.dest_x, rsp.dest_x);
						mismatches++;
					end
					if (rsp.dest_y !== want.dest_y) begin
						$error("dest_y: expected %0d, got %0d", want.dest_y, rsp.dest_y);
						mismatches++;
					end
					if (rsp.tile_col !== want.tile_col) begin
						$error("tile_col: expected %0d, got %0d", want.tile_col, rsp.tile_col);
						mismatches++;
					end
					if (rsp.tile_row !== want.tile_row) begin
						$error("tile_row: expected %0d, got %0d", want.tile_row, rsp.tile_row);
						mismatches++;
					end
					if (rsp.drawn_width !== want.drawn_width) begin
						$error("drawn_width: expected %0d, got %0d", want.drawn_width,
							rsp.drawn_width);
						mismatches++;
					end
					if (rsp.last !== want.last) begin
						$error("last: expected %0d, got %0d", want.last, rsp.last);
						mismatches++;
					end
				end
			end
			if (req_valid && req_ready) begin
				predict_layout(req);
				chars_taken++;
			end
		end
	end

	// Offer words in bursts with gaps; hold each word until it is taken
	int burst_left = 1;
	int gap_left = 0;

	always @(negedge clk) begin
		if (arst_n && chars_offered == chars_taken) begin
			if (gap_left > 0) begin
				gap_left--;
				req_valid <= 1'b0;
			end else if (pending_chars.size() > 0) begin
				req <= pending_chars.pop_front();
				req_valid <= 1'b1;
				chars_offered++;
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Stall the result side on a changing pattern, with two long hold-offs
	int hold_left = 0;
	int holds_done = 0;
	int stall_mode = 0;
	int mode_left = 0;

	always @(negedge clk) begin
		if (hold_left == 0 && holds_done < 2 &&
				chars_taken >= ((holds_done == 0) ? 40 : 220)) begin
			hold_left = HOLD_CYCLES;
			holds_done++;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(16, 80);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: rsp_ready <= 1'b1;
				1: rsp_ready <= $urandom_range(0, 1);
				2: rsp_ready <= ($urandom_range(0, 3) == 0);
				default: rsp_ready <= !rsp_ready;
			endcase
		end
	end

	// Build the stimulus, release reset, then drain and report
	initial begin
		int          random_items;
		int          len;
		int          i;
		int          pick;
		logic [7:0]  c;
		logic [15:0] sx;
		logic [15:0] sy;

		// Idle after reset: ignored until a first word
		pending_chars.push_back(make_word(8'h80, 1'b0, 16'($urandom), 16'($urandom)));
		// Start near the top of the range so x and y wrap
		pending_chars.push_back(make_word(8'h80, 1'b1, 16'h7FF8, 16'h7FFC));
		pending_chars.push_back(make_word(8'hFF, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CODE_NEWLINE, 1'b0, 16'hFFFF, 16'hFFFF));
		pending_chars.push_back(make_word(CODE_TRAINER, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CODE_PLAYER, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CODE_RIVAL, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CTRL_LO, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CTRL_HI, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CODE_PKMN, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CODE_POKE, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CODE_ELLIPSIS, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CODE_PC, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CODE_TM, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CODE_ROCKET, 1'b0, 16'($urandom), 16'($urandom)));
		// Neighbours of the control range draw plain glyphs
		pending_chars.push_back(make_word(8'h47, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(8'h60, 1'b0, 16'($urandom), 16'($urandom)));
		pending_chars.push_back(make_word(CODE_END, 1'b0, 16'($urandom), 16'($urandom)));
		// After the end: ignored
		pending_chars.push_back(make_word(8'h41, 1'b0, 16'($urandom), 16'($urandom)));
		// End code on the first word: zero width
		pending_chars.push_back(make_word(CODE_NUL, 1'b1, 16'h8000, 16'h8000));
		pending_chars.push_back(make_word(8'h01, 1'b1, 16'h8000, 16'h8000));
		pending_chars.push_back(make_word(CODE_NEWLINE, 1'b0, 16'h0000, 16'h0000));
		// Restart in the middle of a string
		pending_chars.push_back(make_word(8'h31, 1'b1, 16'h7FFF, 16'h7FFF));
		pending_chars.push_back(make_word(CODE_NUL, 1'b0, 16'($urandom), 16'($urandom)));

		// Random strings: mostly well formed, some left open, some noise after them
		random_items = 0;
		while (random_items < RANDOM_ITEMS) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 12);
			for (i = 0; i <= len; i++) begin
				pick = $urandom_range(0, 99);
				if (i == 0 && pick < 4)
					c = CODE_NUL;
				else if (pick < 55)
					c = pick_plain();
				else if (pick < 85)
					c = pick_control();
				else if (pick < 93)
					c = CODE_NEWLINE;
				else
					c = 8'($urandom_range(0, 255));
				if (i == 0 || $urandom_range(0, 29) == 0) begin
					if ($urandom_range(0, 7) == 0) begin
						case ($urandom_range(0, 3))
							0: sx = 16'h8000;
							1: sx = 16'h7FFF;
							2: sx = 16'h7FF0;
							default: sx = 16'h0000;
						endcase
						sy = ($urandom_range(0, 1) == 0) ? 16'h7FFC : 16'h8000;
					end else begin
						sx = 16'($urandom);
						sy = 16'($urandom);
					end
					pending_chars.push_back(make_word(c, 1'b1, sx, sy));
				end else begin
					pending_chars.push_back(make_word(c, 1'b0, 16'($urandom), 16'($urandom)));
				end
				random_items++;
			end
			pick = $urandom_range(0, 99);
			if (pick < 90) begin
				pending_chars.push_back(make_word((pick < 45) ? CODE_NUL : CODE_END, 1'b0,
					16'($urandom), 16'($urandom)));
				random_items++;
			end
			if ($urandom_range(0, 2) == 0) begin
				repeat ($urandom_range(1, 3))
					pending_chars.push_back(make_word(8'($urandom), 1'b0,
						16'($urandom), 16'($urandom)));
			end
		end

		repeat (2) @(posedge clk);
		#5 arst_n = 1'b1;

		while (pending_chars.size() != 0 || chars_offered != chars_taken)
			@(negedge clk);
		while (expected_glyphs.size() != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		if (expected_glyphs.size() != 0) begin
			$error("%0d expected result words never arrived", expected_glyphs.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// Stop a hung run
	initial begin
		#5000000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
